>>> hdl/bsb_pkg.sv
// shared constants, codes and step-unit types for the bit stream buffer
package bsb_pkg;

   localparam int STORE_BYTES  = 4096;
   localparam int STORE_ADDR_W = $clog2(STORE_BYTES);
   localparam int ALLOC_W      = 13;
   localparam int CUR_W        = 16;
   localparam int FIELD_BITS   = 64;
   localparam int CNT_W        = 7;
   localparam int OFF_W        = 16;
   localparam int REQ_W        = 96;
   localparam int RSP_W        = 104;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_SEEK  = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   localparam logic [1:0] MODE_START      = 2'd0;
   localparam logic [1:0] MODE_CURSOR     = 2'd1;
   localparam logic [1:0] MODE_END        = 2'd2;
   localparam logic [1:0] MODE_CURSOR_ALT = 2'd3;

   typedef struct packed {
      logic [CUR_W-1:0]   cursor;
      logic [CUR_W-1:0]   end_mark;
      logic [ALLOC_W-1:0] alloc;
      logic [7:0]         work_byte;
      logic               code_bit;
   } bsb_step_in_type;

   typedef struct packed {
      logic [7:0]       new_byte;
      logic             in_range;
      logic             read_bit;
      logic [CUR_W-1:0] cursor_inc;
      logic [CUR_W-1:0] end_next;
      logic             hit_end;
      logic             overflow;
      logic             crossing;
   } bsb_step_out_type;

endpackage

>>> hdl/bsb_store.sv
// byte-wide store with one write port and one registered read port
module bsb_store (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [bsb_pkg::STORE_ADDR_W-1:0] wr_addr,
   input  logic [7:0]                       wr_data,
   input  logic [bsb_pkg::STORE_ADDR_W-1:0] rd_addr,
   output logic [7:0]                       rd_data
);
   import bsb_pkg::*;

   logic [7:0] mem [STORE_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bsb_bit_unit.sv
// shared single-bit step unit: bit insert, bit extract, cursor step and bound checks
module bsb_bit_unit (
   input  bsb_pkg::bsb_step_in_type  step_in,
   output bsb_pkg::bsb_step_out_type step_out
);
   import bsb_pkg::*;

   logic [CUR_W:0] cur_inc;

   always_comb begin
      cur_inc = {1'b0, step_in.cursor} + {{CUR_W{1'b0}}, 1'b1};
      step_out.new_byte = step_in.work_byte;
      for (int b = 0; b < 8; b++) begin
         if (step_in.cursor[2:0] == 3'(b)) begin
            step_out.new_byte[b] = step_in.code_bit;
         end
      end
      step_out.in_range   = step_in.cursor[CUR_W-1:3] < step_in.alloc;
      step_out.read_bit   = step_in.work_byte[step_in.cursor[2:0]];
      step_out.cursor_inc = cur_inc[CUR_W-1:0];
      step_out.end_next   = (cur_inc > {1'b0, step_in.end_mark}) ? cur_inc[CUR_W-1:0]
                                                                 : step_in.end_mark;
      step_out.hit_end    = step_in.cursor >= step_in.end_mark;
      step_out.overflow   = cur_inc[CUR_W:3] >= {1'b0, step_in.alloc};
      step_out.crossing   = cur_inc[2:0] == 3'd0;
   end

endmodule

>>> hdl/bit_stream_buffer.sv
// top level of the bit stream buffer: sequencer, cursor state and result register
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  req_tuser action, req_tdata fields
//  rsp      out  rsp_tvalid/rsp_tready  rsp_tdata fields
//  csr      in   csr_valid/csr_ready    csr_data alloc_size
//
// write/read: accept state, then a fetch state per byte touched and a bit state per bit, then result
// state; seek passes through the seek state to result; clear goes straight to result, or through
// the clear state when the store is zeroed, one byte per cycle on the single store write port
// after reset a clearing pass zeroes all 4096 bytes of the store; req_tready stays low
// a finished item waits in the result state while rsp is stalled; csr is always ready
module bit_stream_buffer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // code_bits[63:0], num_bits[70:64], seek_offset[86:71], seek_mode[88:87],
   // clear_store[89], zero fill
   input  logic [bsb_pkg::REQ_W-1:0] req_tdata,
   // action[1:0]
   input  logic [1:0]                req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // read_value[63:0], bits_done[70:64], status[71], position[87:72], end_position[103:88]
   output logic [bsb_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [bsb_pkg::ALLOC_W-1:0] csr_data
);
   import bsb_pkg::*;

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_FETCH  = 3'd2;
   localparam logic [2:0] S_BIT    = 3'd3;
   localparam logic [2:0] S_SEEK   = 3'd4;
   localparam logic [2:0] S_CLEAR  = 3'd5;
   localparam logic [2:0] S_RESULT = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CUR_W-1:0]        cursor_ff, cursor_in;
   logic [CUR_W-1:0]        end_ff, end_in;
   logic [ALLOC_W-1:0]      alloc_ff;
   logic [STORE_ADDR_W-1:0] sweep_ff, sweep_in;

   logic [1:0]              action_ff, action_in;
   logic [FIELD_BITS-1:0]   code_ff, code_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [FIELD_BITS-1:0]   value_ff, value_in;
   logic [CNT_W-1:0]        done_ff, done_in;
   logic                    status_ff, status_in;
   logic [7:0]              byte_ff, byte_in;
   logic                    fresh_ff, fresh_in;
   logic [OFF_W-1:0]        off_ff, off_in;
   logic [1:0]              mode_ff, mode_in;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;

   logic [ALLOC_W-1:0]      alloc_eff;
   logic                    mem_we;
   logic [STORE_ADDR_W-1:0] mem_waddr;
   logic [7:0]              mem_wdata;
   logic [7:0]              mem_rdata;
   logic [CNT_W-1:0]        req_num;

   logic [CUR_W-1:0]        seek_base;
   logic [CUR_W+1:0]        seek_target;
   logic                    seek_fail;
   logic [CUR_W-1:0]        seek_cursor;

   bsb_step_in_type         step_in;
   bsb_step_out_type        step_out;

   bsb_store u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (cursor_ff[STORE_ADDR_W+2:3]),
      .rd_data (mem_rdata)
   );

   bsb_bit_unit u_bit (
      .step_in  (step_in),
      .step_out (step_out)
   );

   always_comb begin
      if (alloc_ff == '0) begin
         alloc_eff = ALLOC_W'(1);
      end else if (alloc_ff > ALLOC_W'(STORE_BYTES)) begin
         alloc_eff = ALLOC_W'(STORE_BYTES);
      end else begin
         alloc_eff = alloc_ff;
      end
   end

   assign req_num = (req_tdata[70:64] > CNT_W'(FIELD_BITS)) ? CNT_W'(FIELD_BITS)
                                                           : req_tdata[70:64];

   assign step_in.cursor    = cursor_ff;
   assign step_in.end_mark  = end_ff;
   assign step_in.alloc     = alloc_eff;
   assign step_in.work_byte = fresh_ff ? mem_rdata : byte_ff;
   assign step_in.code_bit  = code_ff[0];

   // seek target in 18-bit signed arithmetic
   always_comb begin
      case (mode_ff)
         MODE_START: seek_base = '0;
         MODE_END:   seek_base = end_ff;
         default:    seek_base = cursor_ff;
      endcase
      seek_target = {2'b00, seek_base} + {{2{off_ff[OFF_W-1]}}, off_ff};
      seek_fail   = seek_target[CUR_W+1] ||
                    (seek_target[CUR_W:3] > {1'b0, alloc_eff});
      seek_cursor = seek_fail ? ({alloc_eff, 3'b000} - CUR_W'(1)) : seek_target[CUR_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cursor_in    = cursor_ff;
      end_in       = end_ff;
      sweep_in     = sweep_ff;
      action_in    = action_ff;
      code_in      = code_ff;
      cnt_in       = cnt_ff;
      value_in     = value_ff;
      done_in      = done_ff;
      status_in    = status_ff;
      byte_in      = byte_ff;
      fresh_in     = fresh_ff;
      off_in       = off_ff;
      mode_in      = mode_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = sweep_ff;
      mem_wdata    = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_INIT: begin
            mem_we   = 1'b1;
            sweep_in = sweep_ff + STORE_ADDR_W'(1);
            if (sweep_ff == STORE_ADDR_W'(STORE_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               action_in = req_tuser;
               code_in   = req_tdata[63:0];
               cnt_in    = req_num;
               off_in    = req_tdata[86:71];
               mode_in   = req_tdata[88:87];
               value_in  = '0;
               done_in   = '0;
               status_in = 1'b0;
               sweep_in  = '0;
               unique case (req_tuser)
                  ACT_WRITE, ACT_READ: begin
                     state_in = (req_num == '0) ? S_RESULT : S_FETCH;
                  end
                  ACT_SEEK: begin
                     state_in = S_SEEK;
                  end
                  default: begin
                     cursor_in = '0;
                     end_in    = '0;
                     state_in  = req_tdata[89] ? S_CLEAR : S_RESULT;
                  end
               endcase
            end
         end
         S_FETCH: begin
            fresh_in = 1'b1;
            state_in = S_BIT;
         end
         S_BIT: begin
            fresh_in = 1'b0;
            byte_in  = step_out.new_byte;
            if (action_ff == ACT_WRITE) begin
               mem_waddr = cursor_ff[STORE_ADDR_W+2:3];
               mem_wdata = step_out.new_byte;
               mem_we    = step_out.in_range;
               done_in   = done_ff + CNT_W'(step_out.in_range);
               end_in    = step_out.end_next;
               if (step_out.overflow) begin
                  status_in = 1'b1;
                  state_in  = S_RESULT;
               end else begin
                  cursor_in = step_out.cursor_inc;
                  code_in   = code_ff >> 1;
                  cnt_in    = cnt_ff - CNT_W'(1);
                  if (cnt_ff == CNT_W'(1)) begin
                     state_in = S_RESULT;
                  end else if (step_out.crossing) begin
                     state_in = S_FETCH;
                  end
               end
            end else begin
               if (step_out.hit_end) begin
                  value_in  = value_ff << 1;
                  status_in = 1'b1;
                  state_in  = S_RESULT;
               end else begin
                  value_in  = {value_ff[FIELD_BITS-2:0],
                               step_out.in_range & step_out.read_bit};
                  cursor_in = step_out.cursor_inc;
                  done_in   = done_ff + CNT_W'(1);
                  cnt_in    = cnt_ff - CNT_W'(1);
                  if (cnt_ff == CNT_W'(1)) begin
                     state_in = S_RESULT;
                  end else if (step_out.crossing) begin
                     state_in = S_FETCH;
                  end
               end
            end
         end
         S_SEEK: begin
            cursor_in = seek_cursor;
            end_in    = (seek_cursor > end_ff) ? seek_cursor : end_ff;
            status_in = seek_fail;
            state_in  = S_RESULT;
         end
         S_CLEAR: begin
            mem_we   = 1'b1;
            sweep_in = sweep_ff + STORE_ADDR_W'(1);
            if ({1'b0, sweep_ff} == (alloc_eff - ALLOC_W'(1))) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {end_ff, cursor_ff, status_ff, done_ff, value_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         cursor_ff    <= '0;
         end_ff       <= '0;
         sweep_ff     <= '0;
         alloc_ff     <= ALLOC_W'(STORE_BYTES);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cursor_ff    <= cursor_in;
         end_ff       <= end_in;
         sweep_ff     <= sweep_in;
         if (csr_valid) begin
            alloc_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      code_ff     <= code_in;
      cnt_ff      <= cnt_in;
      value_ff    <= value_in;
      done_ff     <= done_in;
      status_ff   <= status_in;
      byte_ff     <= byte_in;
      fresh_ff    <= fresh_in;
      off_ff      <= off_in;
      mode_ff     <= mode_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule

>>> hdl/bsb_checker.sv
// port-level checks for the bit stream buffer, bound to the top level
module bsb_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [bsb_pkg::RSP_W-1:0]   rsp_tdata
);
   import bsb_pkg::*;

   // stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted while an item is in progress");

   // bits_done never above the field limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[70:64] <= CNT_W'(FIELD_BITS))
      else $error("bits_done out of range");

   // cursor never passes the end mark
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[87:72] <= rsp_tdata[103:88])
      else $error("position beyond end_position");

endmodule

bind bit_stream_buffer bsb_checker u_bsb_checker (.*);

>>> tb/tb_bit_stream_buffer.sv
// self-checking testbench for the bit stream buffer: directed table, random phases, predictor
`timescale 1ns / 100ps

module tb_bit_stream_buffer;
   import bsb_pkg::*;

   localparam int QUIET_LIMIT = 20000;
   localparam int IDLE_PCT    = 22;

   typedef struct {
      logic [1:0]         action;
      logic [63:0]        code;
      logic [CNT_W-1:0]   nbits;
      logic [OFF_W-1:0]   offset;
      logic [1:0]         mode;
      logic               clr;
   } bsb_op_type;

   typedef struct {
      logic [63:0]        value;
      logic [CNT_W-1:0]   done;
      logic               status;
      logic [CUR_W-1:0]   pos;
      logic [CUR_W-1:0]   endp;
   } bsb_res_type;

   typedef struct {
      bsb_op_type  op;
      bit          typed;
      bsb_res_type reply;
   } bsb_row_type;

   logic               clock;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;
   logic [1:0]         req_tuser  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [ALLOC_W-1:0] csr_data   = '0;

   // shadow copy of the block state
   bit [7:0]           shadow_store [STORE_BYTES];
   int                 shadow_cursor = 0;
   int                 shadow_end    = 0;
   logic [ALLOC_W-1:0] shadow_alloc  = 13'd4096;

   bsb_res_type        due_replies [$];
   bsb_row_type        dir_tab [$];
   bit                 cur_typed = 1'b0;
   bsb_res_type        cur_reply;
   bit                 idle_on = 1'b1;
   int                 fault_count = 0;
   int                 quiet_cycles = 0;
   logic [12:0]        alloc_plan [8] = '{13'd1, 13'd3, 13'd0, 13'd17, 13'd64, 13'd8191,
                                          13'd500, 13'd4096};

   bit_stream_buffer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic bsb_res_type apply_buffer_op(bsb_op_type op);
      bsb_res_type r;
      int lim;
      int n;
      int idx;
      int base;
      int target;
      int i;
      r.value  = '0;
      r.done   = '0;
      r.status = 1'b0;
      lim = int'(shadow_alloc);
      if (lim < 1) lim = 1;
      if (lim > STORE_BYTES) lim = STORE_BYTES;
      n = (op.nbits > FIELD_BITS) ? FIELD_BITS : int'(op.nbits);
      case (op.action)
         ACT_WRITE: begin
            for (i = 0; i < n; i++) begin
               idx = shadow_cursor / 8;
               if (idx < lim) begin
                  shadow_store[idx][shadow_cursor % 8] = op.code[i];
                  r.done++;
               end
               shadow_cursor++;
               if (shadow_cursor > shadow_end) shadow_end = shadow_cursor;
               if (shadow_cursor / 8 >= lim) begin
                  shadow_cursor--;
                  r.status = 1'b1;
                  break;
               end
            end
         end
         ACT_READ: begin
            for (i = 0; i < n; i++) begin
               r.value = r.value << 1;
               if (shadow_cursor >= shadow_end) begin
                  r.status = 1'b1;
                  break;
               end
               idx = shadow_cursor / 8;
               if (idx < lim) r.value[0] = shadow_store[idx][shadow_cursor % 8];
               shadow_cursor++;
               r.done++;
            end
         end
         ACT_SEEK: begin
            if (op.mode == MODE_START) base = 0;
            else if (op.mode == MODE_END) base = shadow_end;
            else base = shadow_cursor;
            target = base + $signed(op.offset);
            if (target < 0 || target / 8 > lim) begin
               shadow_cursor = lim * 8 - 1;
               r.status = 1'b1;
            end else begin
               shadow_cursor = target;
            end
            if (shadow_cursor > shadow_end) shadow_end = shadow_cursor;
         end
         default: begin
            shadow_cursor = 0;
            shadow_end = 0;
            if (op.clr) begin
               for (i = 0; i < lim; i++) shadow_store[i] = 8'd0;
            end
         end
      endcase
      shadow_cursor &= 32'hFFFF;
      shadow_end &= 32'hFFFF;
      r.pos  = shadow_cursor[CUR_W-1:0];
      r.endp = shadow_end[CUR_W-1:0];
      return r;
   endfunction

   function automatic bsb_op_type mk(logic [1:0] action, logic [63:0] code, int n, int off,
                                     logic [1:0] mode, bit clr);
      bsb_op_type op;
      op.action = action;
      op.code   = code;
      op.nbits  = n[CNT_W-1:0];
      op.offset = off[OFF_W-1:0];
      op.mode   = mode;
      op.clr    = clr;
      return op;
   endfunction

   function automatic bsb_res_type res(logic [63:0] value, int done, bit status, int pos,
                                       int endp);
      bsb_res_type r;
      r.value  = value;
      r.done   = done[CNT_W-1:0];
      r.status = status;
      r.pos    = pos[CUR_W-1:0];
      r.endp   = endp[CUR_W-1:0];
      return r;
   endfunction

   function automatic bsb_op_type rand_op(int lim);
      bsb_op_type op;
      int sel;
      int span;
      int raw;
      op.code = {$urandom, $urandom};
      sel = $urandom_range(99);
      if (sel < 36) op.action = ACT_WRITE;
      else if (sel < 72) op.action = ACT_READ;
      else if (sel < 93) op.action = ACT_SEEK;
      else op.action = ACT_CLEAR;
      if ($urandom_range(9) == 0) op.nbits = CNT_W'($urandom_range(127, 65));
      else op.nbits = CNT_W'($urandom_range(64));
      op.mode = 2'($urandom_range(3));
      op.clr  = 1'($urandom_range(1));
      sel = $urandom_range(99);
      if (sel < 25) begin
         op.offset = OFF_W'($urandom);
      end else begin
         span = (sel < 60) ? lim * 8 + 16 : 130;
         if (span > 32767) span = 32767;
         raw = $urandom_range(2 * span);
         raw = raw - span;
         op.offset = raw[OFF_W-1:0];
      end
      return op;
   endfunction

   task automatic add_row(input bsb_op_type op, input bit typed, input bsb_res_type reply);
      bsb_row_type row;
      row.op    = op;
      row.typed = typed;
      row.reply = reply;
      dir_tab.push_back(row);
   endtask

   task automatic send_item(input bsb_op_type op, input bit typed, input bsb_res_type reply);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op.action;
      req_tdata  <= {6'd0, op.clr, op.mode, op.offset, op.nbits, op.code};
      cur_typed  <= typed;
      cur_reply  <= reply;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (due_replies.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_alloc(input logic [ALLOC_W-1:0] val);
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
   end

   // predictor and reply check
   always @(posedge clock) begin
      bsb_op_type  op;
      bsb_res_type want;
      bsb_res_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) shadow_alloc = csr_data;
         if (req_tvalid && req_tready) begin
            op.action = req_tuser;
            op.code   = req_tdata[63:0];
            op.nbits  = req_tdata[70:64];
            op.offset = req_tdata[86:71];
            op.mode   = req_tdata[88:87];
            op.clr    = req_tdata[89];
            want = apply_buffer_op(op);
            if (cur_typed) want = cur_reply;
            due_replies.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (due_replies.size() == 0) begin
               $error("reply with no item outstanding: %h", rsp_tdata);
               fault_count++;
            end else begin
               want = due_replies.pop_front();
               got.value  = rsp_tdata[63:0];
               got.done   = rsp_tdata[70:64];
               got.status = rsp_tdata[71];
               got.pos    = rsp_tdata[87:72];
               got.endp   = rsp_tdata[103:88];
               check_field("read_value", want.value, got.value);
               check_field("bits_done", 64'(want.done), 64'(got.done));
               check_field("status", 64'(want.status), 64'(got.status));
               check_field("position", 64'(want.pos), 64'(got.pos));
               check_field("end_position", 64'(want.endp), 64'(got.endp));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_bit_stream_buffer: FAIL");
         $finish;
      end
   end

   initial begin
      bsb_res_type blank;
      int lim;
      blank = res(64'd0, 0, 1'b0, 0, 0);
      cur_reply = blank;

      // directed rows at the reset size of 4096 bytes
      add_row(mk(ACT_READ, 64'd0, 8, 0, MODE_START, 0), 1, res(64'd0, 0, 1, 0, 0));
      add_row(mk(ACT_WRITE, '1, 64, 0, MODE_START, 0), 1, res(64'd0, 64, 0, 64, 64));
      add_row(mk(ACT_SEEK, 64'd0, 0, 0, MODE_START, 0), 1, res(64'd0, 0, 0, 0, 64));
      add_row(mk(ACT_READ, 64'd0, 64, 0, MODE_START, 0), 1, res('1, 64, 0, 64, 64));
      add_row(mk(ACT_READ, 64'd0, 1, 0, MODE_START, 0), 1, res(64'd0, 0, 1, 64, 64));
      add_row(mk(ACT_WRITE, 64'd0, 127, 0, MODE_START, 0), 1, res(64'd0, 64, 0, 128, 128));
      add_row(mk(ACT_SEEK, 64'd0, 0, -128, MODE_END, 0), 1, res(64'd0, 0, 0, 0, 128));
      add_row(mk(ACT_READ, 64'd0, 100, 0, MODE_START, 0), 0, blank);
      add_row(mk(ACT_WRITE, {$urandom, $urandom}, 0, 0, MODE_START, 0), 0, blank);
      add_row(mk(ACT_SEEK, 64'd0, 0, -1, MODE_START, 0), 1, res(64'd0, 0, 1, 32767, 32767));
      add_row(mk(ACT_SEEK, 64'd0, 0, 32760, MODE_START, 0), 0, blank);
      add_row(mk(ACT_WRITE, 64'hA5A5, 16, 0, MODE_START, 0), 0, blank);
      add_row(mk(ACT_SEEK, 64'd0, 0, 1, MODE_CURSOR, 0), 0, blank);
      add_row(mk(ACT_WRITE, {$urandom, $urandom}, 8, 0, MODE_START, 0), 0, blank);
      add_row(mk(ACT_READ, 64'd0, 4, 0, MODE_START, 0), 0, blank);
      add_row(mk(ACT_SEEK, 64'd0, 0, -32768, MODE_CURSOR_ALT, 0), 0, blank);
      add_row(mk(ACT_SEEK, 64'd0, 0, 32767, MODE_END, 0), 0, blank);
      add_row(mk(ACT_SEEK, 64'd0, 0, -32768, MODE_CURSOR, 0), 0, blank);
      add_row(mk(ACT_CLEAR, 64'd0, 0, 0, MODE_START, 1), 1, res(64'd0, 0, 0, 0, 0));
      add_row(mk(ACT_READ, 64'd0, 8, 0, MODE_START, 0), 1, res(64'd0, 0, 1, 0, 0));
      add_row(mk(ACT_WRITE, {$urandom, $urandom}, 64, 0, MODE_START, 0), 0, blank);
      add_row(mk(ACT_SEEK, 64'd0, 0, 24, MODE_START, 0), 0, blank);
      add_row(mk(ACT_READ, 64'd0, 40, 0, MODE_START, 0), 0, blank);
      add_row(mk(ACT_CLEAR, 64'd0, 0, 0, MODE_START, 0), 1, res(64'd0, 0, 0, 0, 0));
      add_row(mk(ACT_SEEK, 64'd0, 0, 40, MODE_START, 0), 0, blank);
      add_row(mk(ACT_READ, 64'd0, 64, 0, MODE_START, 0), 0, blank);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[k]) send_item(dir_tab[k].op, dir_tab[k].typed, dir_tab[k].reply);

      for (int p = 0; p < 8; p++) begin
         settle();
         write_alloc(alloc_plan[p]);
         idle_on <= (p != 3);
         lim = int'(alloc_plan[p]);
         if (lim < 1) lim = 1;
         if (lim > STORE_BYTES) lim = STORE_BYTES;
         repeat (110) send_item(rand_op(lim), 1'b0, blank);
      end

      settle();
      repeat (100) @(posedge clock);
      if (fault_count == 0)
         $display("tb_bit_stream_buffer: PASS");
      else
         $display("tb_bit_stream_buffer: FAIL");
      $finish;
   end

endmodule

>>> bit_stream_buffer.f
hdl/bsb_pkg.sv
hdl/bsb_store.sv
hdl/bsb_bit_unit.sv
hdl/bit_stream_buffer.sv
hdl/bsb_checker.sv
tb/tb_bit_stream_buffer.sv
